// ----- hdl/two_wire_byte_sender_assert.svh -----
// Assertion macros shared by the two-wire sender modules.
// Each macro clocks on "clock" and is disabled while "reset" is high.
`ifndef TWO_WIRE_BYTE_SENDER_ASSERT_SVH
`define TWO_WIRE_BYTE_SENDER_ASSERT_SVH

// Plain property check, one label per use
`define TWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that holds in the cycle after the trigger
`define TWS_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/tws_pkg.sv -----
package tws_pkg;

   localparam int START_W = 20;
   localparam int HALF_W  = 16;
   localparam int HOLD_W  = 20;
   localparam int COUNT_W = 20;
   localparam int BITS_W  = 4;
   localparam int CSR_W   = 20;

   localparam logic [BITS_W-1:0]  BITS_PER_BYTE   = 4'd8;
   localparam logic [START_W-1:0] START_LOW_RESET = 20'd10000;
   localparam logic [HALF_W-1:0]  HALF_BIT_RESET  = 16'd600;
   localparam logic [HOLD_W-1:0]  END_HOLD_RESET  = 20'd4000;

   // Register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_START_LOW = 2'd0,
      CSR_HALF_BIT  = 2'd1,
      CSR_END_HOLD  = 2'd2
   } csr_index_type;

   // Request kinds
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SEND = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_LOW   = 3'd2,
      PH_HIGH  = 3'd3,
      PH_HOLD  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [START_W-1:0] start_low;
      logic [HALF_W-1:0]  half_bit;
      logic [HOLD_W-1:0]  end_hold;
   } cfg_type;

   // Result fields, clock_line in the lowest bit
   typedef struct packed {
      logic send_refused;
      logic busy_res;
      logic data_line;
      logic clock_line;
   } result_type;

endpackage

// ----- hdl/tws_csr.sv -----
module tws_csr import tws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_START_LOW: cfg_in.start_low = csr_wdata[START_W-1:0];
            CSR_HALF_BIT:  cfg_in.half_bit  = csr_wdata[HALF_W-1:0];
            CSR_END_HOLD:  cfg_in.end_hold  = csr_wdata[HOLD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low <= START_LOW_RESET;
         cfg_ff.half_bit  <= HALF_BIT_RESET;
         cfg_ff.end_hold  <= END_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/tws_core.sv -----
module tws_core import tws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       op,
   input  logic [7:0] data_byte,
   input  cfg_type    cfg,
   output result_type res
);

   `include "two_wire_byte_sender_assert.svh"

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         shift_ff, shift_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;

   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] limit;
   logic               done;
   logic [BITS_W-1:0]  bits_dec;

   // Length of the running phase and its end condition
   always_comb begin
      case (phase_ff)
         PH_START: limit = cfg.start_low;
         PH_LOW:   limit = {{(COUNT_W-HALF_W){1'b0}}, cfg.half_bit};
         PH_HIGH:  limit = {{(COUNT_W-HALF_W){1'b0}}, cfg.half_bit};
         PH_HOLD:  limit = cfg.end_hold;
         default:  limit = '0;
      endcase
   end

   assign count_inc = count_ff + 1'b1;
   assign done      = (count_inc >= limit);
   assign bits_dec  = bits_ff - 1'b1;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      if (step_en) begin
         if (op == OP_SEND) begin
            if (phase_ff == PH_IDLE) begin
               shift_in = data_byte;
               bits_in  = BITS_PER_BYTE;
               phase_in = PH_START;
               count_in = '0;
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (done) begin
                     phase_in = PH_LOW;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_LOW: begin
                  if (done) begin
                     phase_in = PH_HIGH;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_HIGH: begin
                  if (done) begin
                     count_in = '0;
                     shift_in = {1'b0, shift_ff[7:1]};
                     bits_in  = bits_dec;
                     if (bits_dec != '0) begin
                        phase_in = PH_LOW;
                     end else if (cfg.end_hold == '0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_HOLD;
                     end
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_HOLD: begin
                  if (done) begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            endcase
         end
      end
   end

   // Line levels follow from the phase being entered
   always_comb begin
      res = '0;
      case (phase_in)
         PH_START: begin
            res.clock_line = 1'b0;
            res.data_line  = 1'b1;
         end
         PH_LOW: begin
            res.clock_line = 1'b0;
            res.data_line  = shift_in[0];
         end
         PH_HIGH: begin
            res.clock_line = 1'b1;
            res.data_line  = shift_in[0];
         end
         default: begin
            res.clock_line = 1'b1;
            res.data_line  = 1'b1;
         end
      endcase
      res.busy_res     = (phase_in != PH_IDLE);
      res.send_refused = (op == OP_SEND) && (phase_ff != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
      end
   end

   // Bit counter is in range whenever a frame is shifting
   `TWS_ASSERT(a_bits_range,
      (phase_ff == PH_START || phase_ff == PH_LOW || phase_ff == PH_HIGH)
         |-> (bits_ff != '0 && bits_ff <= BITS_PER_BYTE),
      "bit count out of range during frame")
   // Idle always has a cleared tick counter
   `TWS_ASSERT(a_idle_count, (phase_ff == PH_IDLE) |-> (count_ff == '0),
      "tick counter not clear in idle")
   // A refused send leaves the timing untouched
   `TWS_ASSERT_NEXT(a_refused_stable, step_en && res.send_refused,
      $stable(phase_ff) && $stable(count_ff) && $stable(shift_ff),
      "refused send changed state")

endmodule

// ----- hdl/two_wire_byte_sender.sv -----
// Two-wire byte sender: drives a clock and a data wire for a serial voice chip.
// Request channel (req_): one request per time tick (tuser = 0) or a send
// request (tuser = 1) carrying the byte in tdata. A send taken while idle starts
// a frame: clock low for start_low_ticks, eight bits LSB first (clock low with
// data set, then clock high, half_bit_ticks each), then both lines high for
// end_hold_ticks. A send while busy is dropped and flagged in the response.
// Response channel (rsp_): exactly one response per request with the line
// levels after that request, the busy flag and the refused flag.
// Path: a taken request is held in the input register, then its response in the
// response register, which drives rsp_tvalid. Throughput: one request per cycle
// while rsp_tready does not stall the response register, set by the single
// state update between the two registers.
// Configuration (csr_): write-only; write only while no frame is running.
// Reset: lines high, idle, registers back to 10000 / 600 / 4000 ticks.
// Receiver stall: the response register holds, the input register takes one
// more request, and req_tready then drops until rsp_tready returns.
module two_wire_byte_sender import tws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tuser,   // [0] operation
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] clock_line, [1] data_line,
                                         // [2] busy_res, [3] send_refused
   // configuration
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   `include "two_wire_byte_sender_assert.svh"

   cfg_type    cfg;
   result_type res;

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic out_free;
   logic step_en;
   logic req_take;

   tws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tws_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .op        (in_op_ff),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .res       (res)
   );

   // Handshake and pipeline advance
   assign out_free     = !out_valid_ff || rsp_tready;
   assign step_en      = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (step_en) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff};

   // Idle response always shows both lines high
   `TWS_ASSERT(a_idle_lines, (rsp_tvalid && !out_res_ff.busy_res)
      |-> (out_res_ff.clock_line && out_res_ff.data_line),
      "lines not high in idle response")

endmodule
